/* rtl/core/assert_macros.svh */
// Assertion macros shared by the checker files.
// They expect clk and an active-low rst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define QKV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under an active-low reset.
`define QKV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/qkv_pkg.sv */
package qkv_pkg;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } qkv_in_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] out_byte;
        logic [3:0] error_code;
        logic       last;
    } qkv_out_t;

    // One queue entry: the results caused by one input byte.
    typedef struct packed {
        qkv_out_t first;
        logic     has_second;
        qkv_out_t second;
    } qkv_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qkv_q_status_t;

    typedef enum logic [3:0] {
        PH_KEY_QUOTE   = 4'd0,
        PH_KEY         = 4'd1,
        PH_AFTER_KEY   = 4'd2,
        PH_AFTER_EQ    = 4'd3,
        PH_VALUE       = 4'd4,
        PH_ESCAPE      = 4'd5,
        PH_AFTER_VALUE = 4'd6
    } qkv_phase_t;

    localparam logic [2:0] KIND_KEY    = 3'd0;
    localparam logic [2:0] KIND_VALUE  = 3'd1;
    localparam logic [2:0] KIND_PAIR   = 3'd2;
    localparam logic [2:0] KIND_ERROR  = 3'd3;
    localparam logic [2:0] KIND_FINISH = 3'd4;

    localparam logic [3:0] ERR_NONE         = 4'd0;
    localparam logic [3:0] ERR_EMPTY        = 4'd1;
    localparam logic [3:0] ERR_QUOTE_BEFORE = 4'd2;
    localparam logic [3:0] ERR_QUOTE_AFTER  = 4'd3;
    localparam logic [3:0] ERR_EARLY_END    = 4'd4;
    localparam logic [3:0] ERR_EQUALS       = 4'd5;
    localparam logic [3:0] ERR_STRING       = 4'd6;
    localparam logic [3:0] ERR_NEWLINE      = 4'd7;
    localparam logic [3:0] ERR_SEMICOLON    = 4'd8;

    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_EQUALS     = 8'h3D;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_BSLASH     = 8'h5C;
    localparam logic [7:0] CH_LOWER_N    = 8'h6E;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_SPACE      = 8'h20;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB) || (c == CH_CR);
    endfunction

    function automatic logic is_key_char(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_UNDERSCORE) || (c == CH_HASH);
    endfunction

    function automatic qkv_out_t make_res(input logic [2:0] kind, input logic [7:0] b,
                                          input logic [3:0] code);
        qkv_out_t r;
        r.kind       = kind;
        r.out_byte   = b;
        r.error_code = code;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

/* rtl/core/quoted_key_value_stream_parser.sv */
// Channel  | Struct     | Handshake               | Carries
// byte     | qkv_in_t   | byte_valid / byte_stall | content byte or end of file
// res      | qkv_out_t  | res_valid / res_stall   | key/value byte, pair done, error, finish
//
// One input byte is taken per cycle while the result queue has room; an item
// causing two results needs two output transfers, so the output side sets the rate.
// byte_stall is high when the QUEUE_DEPTH-entry queue is full; nothing else stalls input.
// Results reach res only after the byte transfer has written them into the queue.
// Reset (rst_n low, asynchronous) empties the queue and returns the parser to between pairs.
module quoted_key_value_stream_parser
#(
    parameter int QUEUE_DEPTH = qkv_pkg::QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  qkv_pkg::qkv_in_t  byte_item,
    output logic              res_valid,
    input  logic              res_stall,
    output qkv_pkg::qkv_out_t res_item
);

    qkv_pkg::qkv_cmd_t      push_cmd;
    qkv_pkg::qkv_cmd_t      head;
    qkv_pkg::qkv_q_status_t q_status;
    logic                   push;
    logic                   pop;
    logic                   accept;

    assign byte_stall = q_status.full;
    assign accept     = byte_valid && !q_status.full;

    qkv_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (byte_item),
        .push   (push),
        .cmd    (push_cmd)
    );

    qkv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    qkv_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .status    (q_status),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule

/* rtl/core/qkv_front.sv */
module qkv_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  qkv_pkg::qkv_in_t  item,
    output logic              push,
    output qkv_pkg::qkv_cmd_t cmd
);

    qkv_pkg::qkv_phase_t phase_reg, phase_next;
    logic                seen_reg, seen_next;
    logic                err_reg, err_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= qkv_pkg::PH_KEY_QUOTE;
            seen_reg  <= 1'b0;
            err_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            seen_reg  <= seen_next;
            err_reg   <= err_next;
        end
    end

    always_comb
    begin
        logic [7:0]       c;
        logic [1:0]       cnt;
        qkv_pkg::qkv_out_t r0;
        qkv_pkg::qkv_out_t r1;

        c          = item.data_byte;
        cnt        = 2'd0;
        r0         = '0;
        r1         = '0;
        phase_next = phase_reg;
        seen_next  = seen_reg;
        err_next   = err_reg;

        if (accept && !err_reg)
        begin
            if (item.end_of_file)
            begin
                unique case (phase_reg)
                    qkv_pkg::PH_KEY:
                    begin
                        r0 = qkv_pkg::make_res(qkv_pkg::KIND_ERROR, 8'h00,
                                               qkv_pkg::ERR_QUOTE_AFTER);
                        cnt = 2'd1;
                        err_next = 1'b1;
                    end
                    qkv_pkg::PH_AFTER_KEY, qkv_pkg::PH_AFTER_EQ, qkv_pkg::PH_VALUE,
                    qkv_pkg::PH_ESCAPE, qkv_pkg::PH_AFTER_VALUE:
                    begin
                        r0 = qkv_pkg::make_res(qkv_pkg::KIND_ERROR, 8'h00,
                                               qkv_pkg::ERR_EARLY_END);
                        cnt = 2'd1;
                        err_next = 1'b1;
                    end
                    default:
                    begin
                        cnt = 2'd1;
                        if (!seen_reg)
                        begin
                            r0 = qkv_pkg::make_res(qkv_pkg::KIND_ERROR, 8'h00,
                                                   qkv_pkg::ERR_EMPTY);
                            err_next = 1'b1;
                        end
                        else
                        begin
                            r0 = qkv_pkg::make_res(qkv_pkg::KIND_FINISH, 8'h00,
                                                   qkv_pkg::ERR_NONE);
                            phase_next = qkv_pkg::PH_KEY_QUOTE;
                            seen_next  = 1'b0;
                        end
                    end
                endcase
            end
            else
            begin
                seen_next = 1'b1;
                unique case (phase_reg)
                    qkv_pkg::PH_KEY:
                    begin
                        if (qkv_pkg::is_key_char(c))
                        begin
                            r0 = qkv_pkg::make_res(qkv_pkg::KIND_KEY, c, qkv_pkg::ERR_NONE);
                            cnt = 2'd1;
                        end
                        else if (c == qkv_pkg::CH_QUOTE)
                            phase_next = qkv_pkg::PH_AFTER_KEY;
                        else
                        begin
                            r0 = qkv_pkg::make_res(qkv_pkg::KIND_ERROR, 8'h00,
                                                   qkv_pkg::ERR_QUOTE_AFTER);
                            cnt = 2'd1;
                            err_next = 1'b1;
                        end
                    end
                    qkv_pkg::PH_AFTER_KEY:
                    begin
                        if (c == qkv_pkg::CH_EQUALS)
                            phase_next = qkv_pkg::PH_AFTER_EQ;
                        else if (!qkv_pkg::is_space(c))
                        begin
                            r0 = qkv_pkg::make_res(qkv_pkg::KIND_ERROR, 8'h00,
                                                   qkv_pkg::ERR_EQUALS);
                            cnt = 2'd1;
                            err_next = 1'b1;
                        end
                    end
                    qkv_pkg::PH_AFTER_EQ:
                    begin
                        if (c == qkv_pkg::CH_QUOTE)
                            phase_next = qkv_pkg::PH_VALUE;
                        else if (!qkv_pkg::is_space(c))
                        begin
                            r0 = qkv_pkg::make_res(qkv_pkg::KIND_ERROR, 8'h00,
                                                   qkv_pkg::ERR_STRING);
                            cnt = 2'd1;
                            err_next = 1'b1;
                        end
                    end
                    qkv_pkg::PH_VALUE:
                    begin
                        priority if (c == qkv_pkg::CH_QUOTE)
                            phase_next = qkv_pkg::PH_AFTER_VALUE;
                        else if (c == qkv_pkg::CH_LF)
                        begin
                            r0 = qkv_pkg::make_res(qkv_pkg::KIND_ERROR, 8'h00,
                                                   qkv_pkg::ERR_NEWLINE);
                            cnt = 2'd1;
                            err_next = 1'b1;
                        end
                        else if (c == qkv_pkg::CH_BSLASH)
                            phase_next = qkv_pkg::PH_ESCAPE;
                        else
                        begin
                            r0 = qkv_pkg::make_res(qkv_pkg::KIND_VALUE, c, qkv_pkg::ERR_NONE);
                            cnt = 2'd1;
                        end
                    end
                    qkv_pkg::PH_ESCAPE:
                    begin
                        phase_next = qkv_pkg::PH_VALUE;
                        cnt = 2'd1;
                        priority if ((c == qkv_pkg::CH_QUOTE) || (c == qkv_pkg::CH_BSLASH))
                            r0 = qkv_pkg::make_res(qkv_pkg::KIND_VALUE, c, qkv_pkg::ERR_NONE);
                        else if (c == qkv_pkg::CH_LOWER_N)
                            r0 = qkv_pkg::make_res(qkv_pkg::KIND_VALUE, qkv_pkg::CH_LF,
                                                   qkv_pkg::ERR_NONE);
                        else
                        begin
                            // unknown escape: keep the backslash, then treat c as plain
                            r0 = qkv_pkg::make_res(qkv_pkg::KIND_VALUE, qkv_pkg::CH_BSLASH,
                                                   qkv_pkg::ERR_NONE);
                            priority if (c == qkv_pkg::CH_LF)
                            begin
                                r1 = qkv_pkg::make_res(qkv_pkg::KIND_ERROR, 8'h00,
                                                       qkv_pkg::ERR_NEWLINE);
                                cnt = 2'd2;
                                err_next = 1'b1;
                            end
                            else
                            begin
                                r1 = qkv_pkg::make_res(qkv_pkg::KIND_VALUE, c,
                                                       qkv_pkg::ERR_NONE);
                                cnt = 2'd2;
                            end
                        end
                    end
                    qkv_pkg::PH_AFTER_VALUE:
                    begin
                        if (c == qkv_pkg::CH_SEMI)
                        begin
                            r0 = qkv_pkg::make_res(qkv_pkg::KIND_PAIR, 8'h00,
                                                   qkv_pkg::ERR_NONE);
                            cnt = 2'd1;
                            phase_next = qkv_pkg::PH_KEY_QUOTE;
                        end
                        else if (!qkv_pkg::is_space(c))
                        begin
                            r0 = qkv_pkg::make_res(qkv_pkg::KIND_ERROR, 8'h00,
                                                   qkv_pkg::ERR_SEMICOLON);
                            cnt = 2'd1;
                            err_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (c == qkv_pkg::CH_QUOTE)
                            phase_next = qkv_pkg::PH_KEY;
                        else if (!qkv_pkg::is_space(c))
                        begin
                            r0 = qkv_pkg::make_res(qkv_pkg::KIND_ERROR, 8'h00,
                                                   qkv_pkg::ERR_QUOTE_BEFORE);
                            cnt = 2'd1;
                            err_next = 1'b1;
                        end
                    end
                endcase
            end
        end

        r0.last = (cnt == 2'd1);
        r1.last = 1'b1;
        push           = (cnt != 2'd0);
        cmd.first      = r0;
        cmd.has_second = (cnt == 2'd2);
        cmd.second     = r1;
    end

endmodule

/* rtl/core/qkv_queue.sv */
module qkv_queue
#(
    parameter int DEPTH = qkv_pkg::QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  qkv_pkg::qkv_cmd_t      push_cmd,
    input  logic                   pop,
    output qkv_pkg::qkv_cmd_t      head,
    output qkv_pkg::qkv_q_status_t status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    qkv_pkg::qkv_cmd_t mem_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

/* rtl/core/qkv_back.sv */
module qkv_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  qkv_pkg::qkv_cmd_t      head,
    input  qkv_pkg::qkv_q_status_t status,
    output logic                   pop,
    output logic                   res_valid,
    input  logic                   res_stall,
    output qkv_pkg::qkv_out_t      res_item
);

    // set while the second result of the head entry is on offer
    logic second_reg, second_next;
    logic xfer;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            second_reg <= 1'b0;
        else
            second_reg <= second_next;
    end

    always_comb
    begin
        res_valid   = !status.empty;
        res_item    = second_reg ? head.second : head.first;
        xfer        = res_valid && !res_stall;
        pop         = xfer && (second_reg || !head.has_second);
        second_next = second_reg;
        if (xfer)
            second_next = !second_reg && head.has_second;
    end

endmodule

/* rtl/core/qkv_checker.sv */
`include "assert_macros.svh"

module qkv_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              byte_valid,
    input logic              byte_stall,
    input qkv_pkg::qkv_in_t  byte_item,
    input logic              res_valid,
    input logic              res_stall,
    input qkv_pkg::qkv_out_t res_item
);

    logic err_seen_reg;
    logic res_xfer;
    logic res_wait;
    logic byte_wait;
    logic lone_kind;
    logic is_error;
    logic has_code;

    assign res_xfer  = res_valid && !res_stall;
    assign res_wait  = res_valid && res_stall;
    assign byte_wait = byte_valid && byte_stall;
    // only a value byte can be the first of two results
    assign lone_kind = res_valid && (res_item.kind != qkv_pkg::KIND_VALUE);
    assign is_error  = (res_item.kind == qkv_pkg::KIND_ERROR);
    assign has_code  = (res_item.error_code != qkv_pkg::ERR_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            err_seen_reg <= 1'b0;
        else if (res_xfer && is_error)
            err_seen_reg <= 1'b1;
    end

    `QKV_ASSERT_NEXT(a_res_hold, res_wait, res_valid && $stable(res_item), "stalled result moved")
    `QKV_ASSERT_NEXT(a_byte_hold, byte_wait, byte_valid && $stable(byte_item), "byte changed")
    `QKV_ASSERT_NOW(a_sticky_error, err_seen_reg, !res_valid, "result after an error")
    `QKV_ASSERT_NOW(a_single_last, lone_kind, res_item.last, "last missing on a lone result")
    `QKV_ASSERT_NOW(a_code_kind, res_valid, is_error == has_code, "error code does not match kind")

endmodule

bind quoted_key_value_stream_parser qkv_checker u_qkv_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item)
);
